// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/cgmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cgmsp_pkg
// Types and constants for the counted-string parameter parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgmsp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LongWordW = 16;
  localparam int unsigned CountW   = LongWordW - 1;
  localparam int unsigned CountHiW = CountW - ByteW;

  localparam logic [ByteW-1:0] LONG_FORM_MARK = 8'hFF;
  localparam logic [ByteW-1:0] CHAR_LO        = 8'h20;
  localparam logic [ByteW-1:0] CHAR_HI        = 8'h7E;
  localparam logic [ByteW-1:0] STR_NUM_MAX    = 8'hFF;

  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_LONG_HI = 2'd1,
    PH_LONG_LO = 2'd2,
    PH_CHARS   = 2'd3
  } phase_e;

endpackage

// ===== hdl/cgm_string_parameter_parser.sv =====
// The result of an accepted input beat is registered and shows in the next cycle.
// 1 byte per cycle while the input is not stalled; the phase/count registers update in one pass.
// Output register holds a stalled result; input stalls only while it is full
// and the downstream side stalls.
// Reset (rst_ni low, async): phase to count byte, counters cleared, no result.
// ----------------------------------------------------------------------------
// cgm_string_parameter_parser
// Splits metafile parameter bytes into counted strings, filters printable
// characters, numbers strings and flags elements that end mid-string or mid-count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgm_string_parameter_parser
  import cgmsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             char_valid_o,
  output logic [ByteW-1:0] char_value_o,
  output logic             string_done_o,
  output logic [ByteW-1:0] string_number_o,
  output logic             element_done_o,
  output logic             parse_error_o
);

  phase_e              phase_q, phase_d, phase_nxt;
  logic [CountW-1:0]   chars_left_q, chars_left_d, chars_left_nxt;
  logic [CountHiW-1:0] count_hi_q, count_hi_d, count_hi_nxt;
  logic [ByteW-1:0]    strings_seen_q, strings_seen_d;

  logic              out_valid_q, out_valid_d;
  logic              char_valid_q, char_valid_d;
  logic [ByteW-1:0]  char_value_q, char_value_d;
  logic              string_done_q, string_done_d;
  logic [ByteW-1:0]  string_number_q;
  logic              element_done_q;
  logic              parse_error_q, parse_error_d;

  logic              accept;
  logic [CountW-1:0] long_count;
  logic              printable;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign long_count = {count_hi_q, data_byte_i};
  assign printable  = (data_byte_i >= CHAR_LO) && (data_byte_i <= CHAR_HI);

  // Next phase
  always_comb begin
    case (phase_q)
      PH_LONG_HI: phase_nxt = PH_LONG_LO;
      PH_LONG_LO: phase_nxt = (long_count == '0) ? PH_COUNT : PH_CHARS;
      PH_CHARS:   phase_nxt = (chars_left_q <= CountW'(1)) ? PH_COUNT : PH_CHARS;
      PH_COUNT: begin
        if (data_byte_i == LONG_FORM_MARK) begin
          phase_nxt = PH_LONG_HI;
        end else if (data_byte_i == '0) begin
          phase_nxt = PH_COUNT;
        end else begin
          phase_nxt = PH_CHARS;
        end
      end
      default:    phase_nxt = PH_COUNT;
    endcase
    if (!accept) begin
      phase_d = phase_q;
    end else if (last_byte_i) begin
      phase_d = PH_COUNT;
    end else begin
      phase_d = phase_nxt;
    end
  end

  // Counters and result fields
  always_comb begin
    chars_left_nxt = chars_left_q;
    count_hi_nxt   = count_hi_q;
    char_valid_d   = 1'b0;
    char_value_d   = '0;
    string_done_d  = 1'b0;
    case (phase_q)
      PH_LONG_HI: begin
        count_hi_nxt = data_byte_i[CountHiW-1:0];
      end
      PH_LONG_LO: begin
        chars_left_nxt = long_count;
        string_done_d  = (long_count == '0);
      end
      PH_CHARS: begin
        char_valid_d = printable;
        char_value_d = printable ? data_byte_i : '0;
        if (chars_left_q <= CountW'(1)) begin
          chars_left_nxt = '0;
          string_done_d  = 1'b1;
        end else begin
          chars_left_nxt = chars_left_q - CountW'(1);
        end
      end
      PH_COUNT: begin
        if (data_byte_i != LONG_FORM_MARK) begin
          chars_left_nxt = CountW'(data_byte_i);
          string_done_d  = (data_byte_i == '0);
        end
      end
      default: begin
        chars_left_nxt = chars_left_q;
      end
    endcase

    parse_error_d = last_byte_i & (phase_nxt != PH_COUNT);

    chars_left_d   = chars_left_q;
    count_hi_d     = count_hi_q;
    strings_seen_d = strings_seen_q;
    if (accept) begin
      if (last_byte_i) begin
        chars_left_d   = '0;
        count_hi_d     = '0;
        strings_seen_d = '0;
      end else begin
        chars_left_d = chars_left_nxt;
        count_hi_d   = count_hi_nxt;
        if (string_done_d && (strings_seen_q != STR_NUM_MAX)) begin
          strings_seen_d = strings_seen_q + ByteW'(1);
        end
      end
    end

    // hold a stalled result, load a new one on every accepted beat
    out_valid_d = accept | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_COUNT;
      chars_left_q   <= '0;
      count_hi_q     <= '0;
      strings_seen_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      chars_left_q   <= chars_left_d;
      count_hi_q     <= count_hi_d;
      strings_seen_q <= strings_seen_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_valid_q    <= char_valid_d;
      char_value_q    <= char_value_d;
      string_done_q   <= string_done_d;
      string_number_q <= strings_seen_q;
      element_done_q  <= last_byte_i;
      parse_error_q   <= parse_error_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign char_valid_o    = char_valid_q;
  assign char_value_o    = char_value_q;
  assign string_done_o   = string_done_q;
  assign string_number_o = string_number_q;
  assign element_done_o  = element_done_q;
  assign parse_error_o   = parse_error_q;

endmodule

// ===== hdl/cgmsp_checker.sv =====
// ----------------------------------------------------------------------------
// cgmsp_checker
// Port-level checks for the counted-string parameter parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cgmsp_checker
  import cgmsp_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [ByteW-1:0] data_byte_i,
  input logic             last_byte_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             char_valid_o,
  input logic [ByteW-1:0] char_value_o,
  input logic             string_done_o,
  input logic [ByteW-1:0] string_number_o,
  input logic             element_done_o,
  input logic             parse_error_o
);

  // an accepted beat always shows up as a result in the next cycle
  `ASSERT_NXT(a_accept_to_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

  // errors are only reported on the element's final beat
  `ASSERT_IMP(a_error_on_last, clk_i, rst_ni, out_valid_o && parse_error_o, element_done_o)

  // kept characters are printable
  `ASSERT_IMP(a_char_printable, clk_i, rst_ni, out_valid_o && char_valid_o, (char_value_o >= CHAR_LO) && (char_value_o <= CHAR_HI))

  // dropped bytes read as zero
  `ASSERT_IMP(a_char_zero, clk_i, rst_ni, out_valid_o && !char_valid_o, char_value_o == '0)

  // a stalled result beat holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(string_number_o) && $stable(string_done_o) && $stable(char_value_o) && $stable(char_valid_o) && $stable(parse_error_o) && $stable(element_done_o))

endmodule

bind cgm_string_parameter_parser cgmsp_checker u_cgmsp_checker (.*);
